>>> hw/rtl/sacl_pkg.sv
package sacl_pkg;

   // Fixed widths of the channel words.
   localparam int ADDR_IN_W   = 32;
   localparam int CNT_W       = 32;
   localparam int WAY_OUT_W   = 2;
   localparam int OFFSET_BITS = 2;

   // Access kinds carried in the op field.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Outcome of the parallel way compare over one set.
   typedef struct packed {
      logic hit;
      logic free_found;
   } lookup_status_type;

endpackage

>>> hw/rtl/sacl_channels.sv
interface sacl_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [sacl_pkg::ADDR_IN_W-1:0] byte_address;

   modport source (output valid, output op, output byte_address, input ready);
   modport sink   (input valid, input op, input byte_address, output ready);
endinterface

interface sacl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [sacl_pkg::WAY_OUT_W-1:0] way_used;
   logic [sacl_pkg::CNT_W-1:0]     hit_total;
   logic [sacl_pkg::CNT_W-1:0]     miss_total;
   logic [sacl_pkg::CNT_W-1:0]     read_total;
   logic [sacl_pkg::CNT_W-1:0]     write_total;

   modport source (output valid, output hit, output way_used, output hit_total,
                   output miss_total, output read_total, output write_total,
                   input ready);
   modport sink   (input valid, input hit, input way_used, input hit_total,
                   input miss_total, input read_total, input write_total,
                   output ready);
endinterface

>>> hw/rtl/set_assoc_cache_lru_tracker_top.sv
// Channel   Dir  Words carried
// --------  ---  ---------------------------------------------------------
// req_chan  in   op, byte_address
// rsp_chan  out  hit, way_used, hit_total, miss_total, read_total, write_total
//
// An access runs accept with set read, lookup and write-back when it hits or
// finds an empty way, plus a scan when every way is valid and the oldest way
// is found one way per cycle. The set memory has one port. Reset clears a
// per-set live flag, the state, the counters and the output valid; an unwritten
// set reads as empty, so there is no clearing pass. The write-back waits while
// the output register holds a word that has not been taken.
module set_assoc_cache_lru_tracker_top #(
   parameter int SETS       = 16,
   parameter int WAYS       = 4,
   parameter int ADDR_WIDTH = 32,
   parameter int AGE_WIDTH  = 16
) (
   input logic        clock,
   input logic        reset,
   sacl_req_if.sink   req_chan,
   sacl_rsp_if.source rsp_chan
);

   localparam int IDX_BITS = $clog2(SETS);
   localparam int TAG_LSB  = sacl_pkg::OFFSET_BITS + IDX_BITS;
   localparam int TAG_W    = ADDR_WIDTH - TAG_LSB;
   localparam int ENT_W    = 1 + TAG_W + AGE_WIDTH;
   localparam int ROW_W    = WAYS * ENT_W;
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [IDX_BITS:0]   SETS_EXT = (IDX_BITS + 1)'(SETS);
   localparam logic [WAY_BITS-1:0] LAST_WAY = WAY_BITS'(WAYS - 1);
   localparam int CW = sacl_pkg::CNT_W;

   logic [ROW_W-1:0] mem [SETS];

   sacl_pkg::state_type state_ff, state_in;
   logic                op_ff, op_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [IDX_BITS-1:0] set_ff, set_in;
   logic [ROW_W-1:0]    row_rd_ff;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                hit_ff, hit_in;
   logic [WAY_BITS-1:0] way_ff, way_in;
   logic [WAY_BITS-1:0] scan_ff, scan_in;
   logic [SETS-1:0]     live_ff, live_in;
   logic [CW-1:0]       hit_cnt_ff, hit_cnt_in;
   logic [CW-1:0]       miss_cnt_ff, miss_cnt_in;
   logic [CW-1:0]       read_cnt_ff, read_cnt_in;
   logic [CW-1:0]       write_cnt_ff, write_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [sacl_pkg::WAY_OUT_W-1:0] rsp_way_ff, rsp_way_in;

   logic [ADDR_WIDTH-1:0] req_addr;
   logic [IDX_BITS-1:0]   req_idx;
   logic [IDX_BITS-1:0]   req_set;
   logic                  mem_rd_en;
   logic                  mem_wr_en;
   logic [ROW_W-1:0]      wr_row;
   logic                  out_free;
   logic [AGE_WIDTH-1:0]  age_of [WAYS];

   logic [ROW_W-1:0]            row_aged;
   sacl_pkg::lookup_status_type lk_status;
   logic [WAY_BITS-1:0]         lk_match_way;
   logic [WAY_BITS-1:0]         lk_free_way;

   sacl_way_lookup #(
      .WAYS      (WAYS),
      .TAG_W     (TAG_W),
      .AGE_WIDTH (AGE_WIDTH)
   ) u_lookup (
      .row_live  (live_ff[set_ff]),
      .row_rd    (row_rd_ff),
      .tag       (tag_ff),
      .row_aged  (row_aged),
      .status    (lk_status),
      .match_way (lk_match_way),
      .free_way  (lk_free_way)
   );

   // The index field is below twice the set count, so one subtract reduces it.
   assign req_addr = ADDR_WIDTH'(req_chan.byte_address);
   assign req_idx  = req_addr[sacl_pkg::OFFSET_BITS +: IDX_BITS];
   assign req_set  = ({1'b0, req_idx} >= SETS_EXT) ? req_idx - SETS_EXT[IDX_BITS-1:0]
                                                   : req_idx;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         age_of[w] = row_ff[w*ENT_W +: AGE_WIDTH];
      end
   end

   // On a miss the chosen way takes the new tag with age zero.
   always_comb begin
      wr_row = row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit_ff && way_ff == WAY_BITS'(w)) begin
            wr_row[w*ENT_W +: ENT_W] = {1'b1, tag_ff, {AGE_WIDTH{1'b0}}};
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tag_in       = tag_ff;
      set_in       = set_ff;
      row_in       = row_ff;
      hit_in       = hit_ff;
      way_in       = way_ff;
      scan_in      = scan_ff;
      live_in      = live_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      read_cnt_in  = read_cnt_ff;
      write_cnt_in = write_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_way_in   = rsp_way_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         sacl_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in     = req_chan.op;
               tag_in    = req_addr[ADDR_WIDTH-1:TAG_LSB];
               set_in    = req_set;
               mem_rd_en = 1'b1;
               state_in  = sacl_pkg::ST_LOOKUP;
            end
         end
         sacl_pkg::ST_LOOKUP: begin
            row_in  = row_aged;
            hit_in  = lk_status.hit;
            scan_in = WAY_BITS'(1);
            priority if (lk_status.hit) begin
               way_in   = lk_match_way;
               state_in = sacl_pkg::ST_FINISH;
            end else if (lk_status.free_found) begin
               way_in   = lk_free_way;
               state_in = sacl_pkg::ST_FINISH;
            end else begin
               way_in   = '0;
               state_in = (WAYS > 1) ? sacl_pkg::ST_SCAN : sacl_pkg::ST_FINISH;
            end
         end
         sacl_pkg::ST_SCAN: begin
            // Oldest way wins; a later way of equal age takes over.
            if (age_of[scan_ff] >= age_of[way_ff]) begin
               way_in = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == LAST_WAY) begin
               state_in = sacl_pkg::ST_FINISH;
            end
         end
         sacl_pkg::ST_FINISH: begin
            if (out_free) begin
               mem_wr_en        = 1'b1;
               live_in[set_ff]  = 1'b1;
               hit_cnt_in       = hit_cnt_ff + CW'(hit_ff);
               miss_cnt_in      = miss_cnt_ff + CW'(!hit_ff);
               read_cnt_in      = read_cnt_ff + CW'(op_ff == sacl_pkg::OP_READ);
               write_cnt_in     = write_cnt_ff + CW'(op_ff == sacl_pkg::OP_WRITE);
               rsp_valid_in     = 1'b1;
               rsp_hit_in       = hit_ff;
               rsp_way_in       = sacl_pkg::WAY_OUT_W'(way_ff);
               state_in         = sacl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[set_ff] <= wr_row;
      end
      if (mem_rd_en) begin
         row_rd_ff <= mem[req_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacl_pkg::ST_IDLE;
         live_ff      <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         read_cnt_ff  <= '0;
         write_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         read_cnt_ff  <= read_cnt_in;
         write_cnt_ff <= write_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      tag_ff     <= tag_in;
      set_ff     <= set_in;
      row_ff     <= row_in;
      hit_ff     <= hit_in;
      way_ff     <= way_in;
      scan_ff    <= scan_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_way_ff <= rsp_way_in;
   end

   // The totals are read from the counters, which change only when a new word loads.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.way_used    = rsp_way_ff;
   assign rsp_chan.hit_total   = hit_cnt_ff;
   assign rsp_chan.miss_total  = miss_cnt_ff;
   assign rsp_chan.read_total  = read_cnt_ff;
   assign rsp_chan.write_total = write_cnt_ff;

endmodule

>>> hw/rtl/sacl_way_lookup.sv
module sacl_way_lookup #(
   parameter int WAYS      = 4,
   parameter int TAG_W     = 26,
   parameter int AGE_WIDTH = 16,
   localparam int ENT_W    = 1 + TAG_W + AGE_WIDTH,
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                          row_live,
   input  logic [WAYS*ENT_W-1:0]         row_rd,
   input  logic [TAG_W-1:0]              tag,
   output logic [WAYS*ENT_W-1:0]         row_aged,
   output sacl_pkg::lookup_status_type   status,
   output logic [WAY_BITS-1:0]           match_way,
   output logic [WAY_BITS-1:0]           free_way
);

   localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

   always_comb begin
      logic                 v;
      logic [TAG_W-1:0]     t;
      logic [AGE_WIDTH-1:0] a;
      row_aged  = '0;
      status    = '0;
      match_way = '0;
      free_way  = '0;
      for (int w = 0; w < WAYS; w++) begin
         // A set never written since reset reads as all ways empty.
         v = row_live & row_rd[w*ENT_W + ENT_W - 1];
         t = row_live ? row_rd[w*ENT_W + AGE_WIDTH +: TAG_W] : '0;
         a = row_live ? row_rd[w*ENT_W +: AGE_WIDTH] : '0;
         if (v) begin
            if (a != AGE_MAX) begin
               a = a + 1'b1;
            end
            if (t == tag) begin
               a          = '0;
               status.hit = 1'b1;
               match_way  = WAY_BITS'(w);
            end
         end else if (!status.free_found) begin
            status.free_found = 1'b1;
            free_way          = WAY_BITS'(w);
         end
         row_aged[w*ENT_W +: ENT_W] = {v, t, a};
      end
   end

endmodule

>>> hw/rtl/sacl_checker.sv
module sacl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_hit,
   input logic [sacl_pkg::WAY_OUT_W-1:0] rsp_way_used,
   input logic [sacl_pkg::CNT_W-1:0]     rsp_hit_total,
   input logic [sacl_pkg::CNT_W-1:0]     rsp_miss_total,
   input logic [sacl_pkg::CNT_W-1:0]     rsp_read_total,
   input logic [sacl_pkg::CNT_W-1:0]     rsp_write_total
);

   localparam int CW = sacl_pkg::CNT_W;

   // A stalled result word keeps its hit, way, hit total and miss total.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_way_used)
                                  && $stable(rsp_hit_total) && $stable(rsp_miss_total))
      else $error("result word changed while stalled");

   // Every access is either a hit or a miss and either a read or a write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> CW'(rsp_hit_total + rsp_miss_total)
                    == CW'(rsp_read_total + rsp_write_total))
      else $error("hit and miss totals disagree with read and write totals");

   // One access at a time: the lookup keeps the request side closed.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an access is in flight");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind set_assoc_cache_lru_tracker_top sacl_checker u_sacl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hit         (rsp_chan.hit),
   .rsp_way_used    (rsp_chan.way_used),
   .rsp_hit_total   (rsp_chan.hit_total),
   .rsp_miss_total  (rsp_chan.miss_total),
   .rsp_read_total  (rsp_chan.read_total),
   .rsp_write_total (rsp_chan.write_total)
);
